/* src/fdes_pkg.sv */
package fdes_pkg;

   // Directory entry layout
   localparam int unsigned EntryBytes  = 32;
   localparam int unsigned NameBytes   = 11;
   localparam int unsigned WordCount   = 7;
   localparam int unsigned PosWidth    = 5;

   localparam logic [7:0] MARK_DELETED = 8'hE5;
   localparam logic [7:0] MARK_END     = 8'h00;
   localparam logic [7:0] NAME_PAD     = 8'h20;

   localparam logic [PosWidth-1:0] POS_FIRST    = 5'd0;
   localparam logic [PosWidth-1:0] POS_NAME_END = 5'd11;
   localparam logic [PosWidth-1:0] POS_NAME_TOP = 5'd10;
   localparam logic [PosWidth-1:0] POS_ATTR     = 5'd11;
   localparam logic [PosWidth-1:0] POS_WORDS    = 5'd14;
   localparam logic [PosWidth-1:0] POS_SIZE     = 5'd28;
   localparam logic [PosWidth-1:0] POS_LAST     = 5'd31;
   localparam logic [3:0]          FULL_NAME_LEN = 4'd11;

   // Configuration register indexes
   localparam logic [1:0] REG_NAME_FIRST8 = 2'd0;
   localparam logic [1:0] REG_NAME_LAST3  = 2'd1;
   localparam logic [1:0] REG_NAME_LENGTH = 2'd2;

   typedef struct packed {
      logic [63:0] name_first8;
      logic [23:0] name_last3;
      logic [3:0]  name_length;
   } fdes_cfg_type;

   typedef struct packed {
      logic [31:0] file_size;
      logic [15:0] cluster_low;
      logic [15:0] write_date;
      logic [15:0] write_time;
      logic [15:0] cluster_high;
      logic [15:0] access_date;
      logic [15:0] create_date;
      logic [15:0] create_time;
      logic [7:0]  attributes;
      logic        found;
   } fdes_result_type;

   // Target name byte at name position idx (0 to 10)
   function automatic logic [7:0] target_byte(fdes_cfg_type cfg, logic [3:0] idx);
      logic [7:0] tb;
      tb = 8'h00;
      unique case (idx)
         4'd0:  tb = cfg.name_first8[7:0];
         4'd1:  tb = cfg.name_first8[15:8];
         4'd2:  tb = cfg.name_first8[23:16];
         4'd3:  tb = cfg.name_first8[31:24];
         4'd4:  tb = cfg.name_first8[39:32];
         4'd5:  tb = cfg.name_first8[47:40];
         4'd6:  tb = cfg.name_first8[55:48];
         4'd7:  tb = cfg.name_first8[63:56];
         4'd8:  tb = cfg.name_last3[7:0];
         4'd9:  tb = cfg.name_last3[15:8];
         4'd10: tb = cfg.name_last3[23:16];
         default: tb = 8'h00;
      endcase
      return tb;
   endfunction

endpackage

/* src/fdes_csr.sv */
module fdes_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [4:0]           csr_paddr,
   input  logic [63:0]          csr_pwdata,
   output logic [63:0]          csr_prdata,
   output logic                 csr_pready,
   output fdes_pkg::fdes_cfg_type cfg
);
   import fdes_pkg::*;

   logic [63:0] name_first8_ff;
   logic [23:0] name_last3_ff;
   logic [3:0]  name_length_ff;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:3];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Write registers on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         name_first8_ff <= '0;
         name_last3_ff  <= '0;
         name_length_ff <= '0;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_NAME_FIRST8: name_first8_ff <= csr_pwdata;
            REG_NAME_LAST3:  name_last3_ff  <= csr_pwdata[23:0];
            REG_NAME_LENGTH: name_length_ff <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (reg_idx)
         REG_NAME_FIRST8: csr_prdata = name_first8_ff;
         REG_NAME_LAST3:  csr_prdata = {40'd0, name_last3_ff};
         REG_NAME_LENGTH: csr_prdata = {60'd0, name_length_ff};
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg.name_first8 = name_first8_ff;
   assign cfg.name_last3  = name_last3_ff;
   assign cfg.name_length = name_length_ff;

endmodule

/* src/fdes_scan.sv */
module fdes_scan (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  logic [7:0]                dir_byte,
   input  logic                      final_byte,
   input  fdes_pkg::fdes_cfg_type    cfg,
   output logic                      res_valid,
   output fdes_pkg::fdes_result_type res
);
   import fdes_pkg::*;

   logic [PosWidth-1:0] pos_ff, pos_in;
   logic                skip_ff, skip_in;
   logic                match_ff, match_in;
   logic                ended_ff, ended_in;
   logic                fin_ff, fin_in;

   logic [7:0]          attr_ff, attr_in;
   logic [15:0]         words_ff [WordCount];
   logic [15:0]         words_in [WordCount];
   logic [31:0]         size_ff, size_in;

   logic                end_mark;
   logic                deleted;
   logic                name_match;
   logic                name_ended;
   logic                hit;
   logic [7:0]          tgt;
   logic [PosWidth-1:0] word_off;
   logic [2:0]          word_idx;
   logic [4:0]          len_ext;

   assign len_ext  = {1'b0, cfg.name_length};
   assign tgt      = target_byte(cfg, pos_ff[3:0]);
   assign end_mark = (pos_ff == POS_FIRST) && (dir_byte == MARK_END);
   assign deleted  = skip_ff || ((pos_ff == POS_FIRST) && (dir_byte == MARK_DELETED));
   assign word_off = pos_ff - POS_WORDS;
   assign word_idx = word_off[3:1];

   // Compare the short name one byte at a time
   always_comb begin
      name_match = match_ff;
      name_ended = ended_ff;
      if ((pos_ff < POS_NAME_END) && !ended_ff) begin
         if (dir_byte == NAME_PAD) begin
            name_ended = 1'b1;
            if (pos_ff != len_ext) name_match = 1'b0;
         end else begin
            if ((pos_ff >= len_ext) || (dir_byte != tgt)) name_match = 1'b0;
            if ((pos_ff == POS_NAME_TOP) && (cfg.name_length != FULL_NAME_LEN))
               name_match = 1'b0;
         end
      end
   end

   assign hit = !fin_ff && !end_mark && (pos_ff == POS_LAST) && !deleted && name_match;

   // Next state for one accepted byte
   always_comb begin
      pos_in   = pos_ff;
      skip_in  = skip_ff;
      match_in = match_ff;
      ended_in = ended_ff;
      fin_in   = fin_ff;
      attr_in  = attr_ff;
      size_in  = size_ff;
      for (int k = 0; k < WordCount; k++) words_in[k] = words_ff[k];
      res_valid = 1'b0;

      if (!fin_ff) begin
         if (end_mark) begin
            res_valid = 1'b1;
            fin_in    = 1'b1;
         end else begin
            skip_in  = deleted;
            match_in = name_match;
            ended_in = name_ended;
            if (pos_ff == POS_ATTR) attr_in = dir_byte;
            if ((pos_ff >= POS_WORDS) && (pos_ff < POS_SIZE)) begin
               if (pos_ff[0]) words_in[word_idx][15:8] = dir_byte;
               else           words_in[word_idx] = {8'h00, dir_byte};
            end
            if (pos_ff >= POS_SIZE) begin
               unique case (pos_ff[1:0])
                  2'd0: size_in[7:0]   = dir_byte;
                  2'd1: size_in[15:8]  = dir_byte;
                  2'd2: size_in[23:16] = dir_byte;
                  2'd3: size_in[31:24] = dir_byte;
                  default: ;
               endcase
            end
            if (pos_ff == POS_LAST) begin
               res_valid = hit;
               fin_in    = hit;
               skip_in   = 1'b0;
               match_in  = 1'b1;
               ended_in  = 1'b0;
            end
            pos_in = pos_ff + 5'd1;
         end
      end

      // Final byte: give a result if none was given yet (not-found unless this byte completes a match), then rearm
      if (final_byte) begin
         if (!fin_ff) res_valid = 1'b1;
         pos_in   = POS_FIRST;
         fin_in   = 1'b0;
         skip_in  = 1'b0;
         match_in = 1'b1;
         ended_in = 1'b0;
      end
   end

   // Build the result from the captured fields
   always_comb begin
      res = '0;
      if (hit) begin
         res.found        = 1'b1;
         res.attributes   = attr_ff;
         res.create_time  = words_ff[0];
         res.create_date  = words_ff[1];
         res.access_date  = words_ff[2];
         res.cluster_high = words_ff[3];
         res.write_time   = words_ff[4];
         res.write_date   = words_ff[5];
         res.cluster_low  = words_ff[6];
         res.file_size    = {dir_byte, size_ff[23:0]};
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_FIRST;
         skip_ff  <= 1'b0;
         match_ff <= 1'b1;
         ended_ff <= 1'b0;
         fin_ff   <= 1'b0;
      end else if (fire) begin
         pos_ff   <= pos_in;
         skip_ff  <= skip_in;
         match_ff <= match_in;
         ended_ff <= ended_in;
         fin_ff   <= fin_in;
      end
   end

   // Captured entry fields
   always_ff @(posedge clock) begin
      if (fire) begin
         attr_ff <= attr_in;
         size_ff <= size_in;
         for (int k = 0; k < WordCount; k++) words_ff[k] <= words_in[k];
      end
   end

   ap_hold_when_done: assert property (@(posedge clock) disable iff (reset)
      fire && fin_ff && !final_byte |=> $stable(pos_ff) && fin_ff)
      else $error("entry position moved while ignoring bytes");

   ap_hit_at_entry_end: assert property (@(posedge clock) disable iff (reset)
      fire && res_valid && res.found |-> pos_ff == POS_LAST)
      else $error("match reported away from the last entry byte");

   ap_rearm_on_final: assert property (@(posedge clock) disable iff (reset)
      fire && final_byte |=> !fin_ff && pos_ff == POS_FIRST && match_ff)
      else $error("search not rearmed after the final byte");

endmodule

/* src/fat_directory_entry_search_core.sv */
// FAT directory entry search. Directory bytes enter one per word on req_, with
// req_tlast on the last byte of the directory; one word is taken every clock
// cycle while the input does not stall. Each byte passes an input register,
// then the name compare and field capture, then lands in the result register;
// a result is completed by the last byte of the matching entry, a first byte of
// 0x00, or the final byte. Input stalls only while the result register holds an
// untaken word and the input register is also full. At most one result is
// given per directory; bytes after it are dropped until the final byte. The
// target name is set through csr_ at byte addresses 0, 8 and 16 and must be
// written while no directory is in flight.
module fat_directory_entry_search_core (
   input  logic          clock,
   input  logic          reset,
   // dir_byte [7:0]
   input  logic [7:0]    req_tdata,
   input  logic          req_tlast,
   input  logic          req_tvalid,
   output logic          req_tready,
   // found [0], attributes [8:1], create_time [24:9], create_date [40:25],
   // access_date [56:41], cluster_high [72:57], write_time [88:73],
   // write_date [104:89], cluster_low [120:105], file_size [152:121], zero pad
   output logic [159:0]  rsp_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [4:0]    csr_paddr,
   input  logic [63:0]   csr_pwdata,
   output logic [63:0]   csr_prdata,
   output logic          csr_pready
);
   import fdes_pkg::*;

   fdes_cfg_type    cfg;
   fdes_result_type res;
   logic            res_valid;

   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            in_last_ff;
   logic            out_valid_ff, out_valid_in;
   fdes_result_type out_data_ff;
   logic            advance;

   fdes_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fdes_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .dir_byte   (in_byte_ff),
      .final_byte (in_last_ff),
      .cfg        (cfg),
      .res_valid  (res_valid),
      .res        (res)
   );

   // Advance the held word when the result register can take its output
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Result register
   assign out_valid_in = (advance && res_valid) || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         out_data_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_data_ff};

   ap_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && out_valid_ff && !rsp_tready)
      else $error("input stalled with room downstream");

   ap_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |-> !(advance && res_valid))
      else $error("result register overwritten while held");

   ap_result_from_word: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(in_valid_ff))
      else $error("result appeared without an input word");

endmodule
